>>> design/mail_header_line_parser_defines.svh
// Assertion macros shared by the mail header line parser.
`ifndef MAIL_HEADER_LINE_PARSER_DEFINES_SVH
`define MAIL_HEADER_LINE_PARSER_DEFINES_SVH

// Plain property checked at every clock edge outside reset.
`define MHLP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mhlp: property failed");

// Same-cycle implication checked outside reset.
`define MHLP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mhlp: implication failed");

`endif

>>> design/mhlp_pkg.sv
// Shared types and constants of the mail header line parser.
package mhlp_pkg;

  localparam int LEN_BITS_DEF   = 16;
  localparam int TOTAL_BITS_DEF = 32;

  // Result queue geometry.
  localparam int Q_DEPTH = 8;
  localparam int Q_PTR_W = 3;
  localparam int Q_CNT_W = 4;

  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  typedef enum logic [1:0] {
    KIND_FIELD    = 2'd0,
    KIND_NO_COLON = 2'd1,
    KIND_CONT     = 2'd2,
    KIND_END      = 2'd3
  } kind_e;

  // Which of the two result slots the parser fills this cycle.
  typedef struct packed {
    logic a_valid;
    logic b_valid;
  } push_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] level;
    logic               low_space;
  } q_status_t;

endpackage

>>> design/mhlp_core.sv
// Input register, per-byte line parsing and line state of the header parser.
module mhlp_core import mhlp_pkg::*; #(
  parameter int LEN_BITS   = LEN_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF,
  parameter int REC_W      = 2 + 3 * LEN_BITS + 4 + 3 * TOTAL_BITS + 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  input  logic             stall_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_input_i,
  output push_t            push_o,
  output logic [REC_W-1:0] rec_a_o,
  output logic [REC_W-1:0] rec_b_o
);

  typedef struct packed {
    kind_e                 kind;
    logic [LEN_BITS-1:0]   name;
    logic [LEN_BITS-1:0]   middle;
    logic [LEN_BITS-1:0]   value;
    logic                  crlf;
    logic                  nonl;
    logic                  cont;
    logic                  nul;
    logic [TOTAL_BITS-1:0] lines;
    logic [TOTAL_BITS-1:0] phys;
    logic [TOTAL_BITS-1:0] virt;
    logic                  last;
  } rec_t;

  localparam logic [LEN_BITS-1:0]   LEN_MAX = '1;
  localparam logic [TOTAL_BITS-1:0] TOT_MAX = '1;

  // Input register.
  logic       vld_q;
  logic [7:0] byte_q;
  logic       eoi_q;

  logic skip_q;

  // Held record of the previous line.
  logic                held_vld_q, held_vld_d;
  kind_e               held_kind_q, held_kind_d;
  logic [LEN_BITS-1:0] held_name_q, held_name_d;
  logic [LEN_BITS-1:0] held_mid_q, held_mid_d;
  logic [LEN_BITS-1:0] held_val_q, held_val_d;
  logic                held_crlf_q, held_crlf_d;
  logic                held_nonl_q, held_nonl_d;

  // Current line state.
  logic [LEN_BITS-1:0] pos_q, pos_d;
  logic [LEN_BITS-1:0] colon_q, colon_d;
  logic                colon_fnd_q, colon_fnd_d;
  logic [LEN_BITS-1:0] name_end_q, name_end_d;
  logic [LEN_BITS-1:0] vstart_q, vstart_d;
  logic                vstart_fnd_q, vstart_fnd_d;
  logic                cont_q, cont_d;
  logic                prev_cr_q, prev_cr_d;
  logic                first_lwsp_q, first_lwsp_d;
  logic                done_q, done_d;
  logic                nul_q, nul_d;
  logic [TOTAL_BITS-1:0] lines_q, lines_d;
  logic [TOTAL_BITS-1:0] phys_q, phys_d;
  logic [TOTAL_BITS-1:0] virt_q, virt_d;

  logic                process;
  logic                is_lf, is_lwsp;
  logic                cont_line;
  logic [LEN_BITS-1:0] pos_inc;

  // Record builder signals.
  logic [LEN_BITS-1:0] s_b;
  logic                crlf_b, nonl_b, cont_b;
  kind_e               kind_b;
  logic [LEN_BITS-1:0] name_b, mid_b, val_b;
  logic [LEN_BITS-1:0] vlen, n_len, pos_a, pos_bb, pos_sel, pos_c;
  logic                all_lwsp;
  logic [LEN_BITS:0]   mid_w;

  logic [TOTAL_BITS:0]   virt_sum;
  logic [TOTAL_BITS-1:0] lines_n, phys_n, virt_n;
  logic                  nul_n;

  rec_t rec_a, rec_b;

  assign process = vld_q && !done_q;
  assign is_lf   = (byte_q == CHAR_LF);
  assign is_lwsp = (byte_q == CHAR_SP) || (byte_q == CHAR_TAB);
  assign cont_line = held_vld_q ? is_lwsp : cont_q;
  assign pos_inc = (pos_q == LEN_MAX) ? pos_q : pos_q + LEN_BITS'(1);

  // Record of the current line, for a line feed or for the end of the stream.
  always_comb begin
    if (eoi_q) begin
      s_b = pos_q;
    end else if (prev_cr_q && (pos_q != '0)) begin
      s_b = pos_q - LEN_BITS'(1);
    end else begin
      s_b = pos_q;
    end
    crlf_b = !eoi_q && prev_cr_q;
    nonl_b = eoi_q;
    cont_b = eoi_q ? cont_q : cont_line;

    vlen     = (s_b > colon_q) ? s_b - colon_q - LEN_BITS'(1) : '0;
    all_lwsp = !vstart_fnd_q || (vstart_q >= s_b);
    n_len    = (name_end_q > colon_q) ? colon_q : name_end_q;
    pos_a    = (vstart_q > colon_q) ? vstart_q - colon_q - LEN_BITS'(1) : '0;
    pos_bb   = ((vlen != '0) && first_lwsp_q) ? LEN_BITS'(1) : '0;
    pos_sel  = (skip_q && !all_lwsp) ? pos_a : pos_bb;
    pos_c    = (pos_sel > vlen) ? vlen : pos_sel;
    mid_w    = {1'b0, colon_q} + (LEN_BITS+1)'(1) + {1'b0, pos_c} - {1'b0, n_len};

    name_b = '0;
    mid_b  = '0;
    val_b  = '0;
    if ((s_b == '0) && !nonl_b) begin
      kind_b = KIND_END;
    end else if (cont_b) begin
      kind_b = KIND_CONT;
      val_b  = s_b;
    end else if (!colon_fnd_q) begin
      kind_b = KIND_NO_COLON;
      name_b = s_b;
    end else begin
      kind_b = KIND_FIELD;
      name_b = n_len;
      mid_b  = mid_w[LEN_BITS] ? LEN_MAX : mid_w[LEN_BITS-1:0];
      val_b  = vlen - pos_c;
    end
  end

  // Totals after this byte; a bare line feed counts twice in the virtual total.
  always_comb begin
    virt_sum = {1'b0, virt_q} + (TOTAL_BITS+1)'(1)
             + (TOTAL_BITS+1)'(is_lf && !prev_cr_q);
    if (eoi_q) begin
      lines_n = lines_q;
      phys_n  = phys_q;
      virt_n  = virt_q;
      nul_n   = nul_q;
    end else begin
      lines_n = (is_lf && (lines_q != TOT_MAX)) ? lines_q + TOTAL_BITS'(1) : lines_q;
      phys_n  = (phys_q == TOT_MAX) ? phys_q : phys_q + TOTAL_BITS'(1);
      virt_n  = (virt_sum > {1'b0, TOT_MAX}) ? TOT_MAX : virt_sum[TOTAL_BITS-1:0];
      nul_n   = nul_q || (byte_q == CHAR_NUL);
    end
  end

  always_comb begin
    push_o.a_valid = process && held_vld_q;
    if (eoi_q) begin
      push_o.b_valid = process && !held_vld_q && (pos_q != '0);
    end else begin
      push_o.b_valid = process && is_lf && (kind_b == KIND_END);
    end

    rec_a.kind   = held_kind_q;
    rec_a.name   = held_name_q;
    rec_a.middle = held_mid_q;
    rec_a.value  = held_val_q;
    rec_a.crlf   = held_crlf_q;
    rec_a.nonl   = held_nonl_q;
    rec_a.cont   = !eoi_q && is_lwsp;
    rec_a.nul    = nul_q;
    rec_a.lines  = lines_q;
    rec_a.phys   = phys_q;
    rec_a.virt   = virt_q;
    rec_a.last   = !push_o.b_valid;

    rec_b.kind   = kind_b;
    rec_b.name   = name_b;
    rec_b.middle = mid_b;
    rec_b.value  = val_b;
    rec_b.crlf   = crlf_b;
    rec_b.nonl   = nonl_b;
    rec_b.cont   = 1'b0;
    rec_b.nul    = nul_n;
    rec_b.lines  = lines_n;
    rec_b.phys   = phys_n;
    rec_b.virt   = virt_n;
    rec_b.last   = 1'b1;
  end

  assign rec_a_o = rec_a;
  assign rec_b_o = rec_b;

  always_comb begin
    held_vld_d   = held_vld_q;
    held_kind_d  = held_kind_q;
    held_name_d  = held_name_q;
    held_mid_d   = held_mid_q;
    held_val_d   = held_val_q;
    held_crlf_d  = held_crlf_q;
    held_nonl_d  = held_nonl_q;
    pos_d        = pos_q;
    colon_d      = colon_q;
    colon_fnd_d  = colon_fnd_q;
    name_end_d   = name_end_q;
    vstart_d     = vstart_q;
    vstart_fnd_d = vstart_fnd_q;
    cont_d       = cont_q;
    prev_cr_d    = prev_cr_q;
    first_lwsp_d = first_lwsp_q;
    done_d       = done_q;
    nul_d        = nul_n;
    lines_d      = lines_n;
    phys_d       = phys_n;
    virt_d       = virt_n;

    if (!process) begin
      nul_d   = nul_q;
      lines_d = lines_q;
      phys_d  = phys_q;
      virt_d  = virt_q;
    end else if (eoi_q || is_lf) begin
      // The line is finished: either hold its record or close the stream.
      held_vld_d   = !eoi_q && (kind_b != KIND_END);
      held_kind_d  = kind_b;
      held_name_d  = name_b;
      held_mid_d   = mid_b;
      held_val_d   = val_b;
      held_crlf_d  = crlf_b;
      held_nonl_d  = nonl_b;
      done_d       = eoi_q || (kind_b == KIND_END);
      pos_d        = '0;
      colon_d      = '0;
      colon_fnd_d  = 1'b0;
      name_end_d   = '0;
      vstart_d     = '0;
      vstart_fnd_d = 1'b0;
      cont_d       = 1'b0;
      prev_cr_d    = 1'b0;
      first_lwsp_d = 1'b0;
    end else begin
      held_vld_d = 1'b0;
      cont_d     = cont_line;
      if (!cont_line) begin
        if (!colon_fnd_q) begin
          if (byte_q == CHAR_COLON) begin
            colon_fnd_d = 1'b1;
            colon_d     = pos_q;
          end else if (!is_lwsp) begin
            name_end_d = pos_inc;
          end
        end else begin
          if (({1'b0, pos_q} == {1'b0, colon_q} + (LEN_BITS+1)'(1)) && is_lwsp) begin
            first_lwsp_d = 1'b1;
          end
          if (!vstart_fnd_q && !is_lwsp) begin
            vstart_fnd_d = 1'b1;
            vstart_d     = pos_q;
          end
        end
      end
      pos_d     = pos_inc;
      prev_cr_d = (byte_q == CHAR_CR);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= 1'b0;
      skip_q       <= 1'b1;
      held_vld_q   <= 1'b0;
      pos_q        <= '0;
      colon_q      <= '0;
      colon_fnd_q  <= 1'b0;
      name_end_q   <= '0;
      vstart_q     <= '0;
      vstart_fnd_q <= 1'b0;
      cont_q       <= 1'b0;
      prev_cr_q    <= 1'b0;
      first_lwsp_q <= 1'b0;
      done_q       <= 1'b0;
      nul_q        <= 1'b0;
      lines_q      <= '0;
      phys_q       <= '0;
      virt_q       <= '0;
    end else begin
      vld_q        <= in_valid_i && !stall_i;
      if (cfg_we_i) begin
        skip_q <= cfg_wdata_i;
      end
      held_vld_q   <= held_vld_d;
      pos_q        <= pos_d;
      colon_q      <= colon_d;
      colon_fnd_q  <= colon_fnd_d;
      name_end_q   <= name_end_d;
      vstart_q     <= vstart_d;
      vstart_fnd_q <= vstart_fnd_d;
      cont_q       <= cont_d;
      prev_cr_q    <= prev_cr_d;
      first_lwsp_q <= first_lwsp_d;
      done_q       <= done_d;
      nul_q        <= nul_d;
      lines_q      <= lines_d;
      phys_q       <= phys_d;
      virt_q       <= virt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !stall_i) begin
      byte_q <= data_byte_i;
      eoi_q  <= end_of_input_i;
    end
    held_kind_q <= held_kind_d;
    held_name_q <= held_name_d;
    held_mid_q  <= held_mid_d;
    held_val_q  <= held_val_d;
    held_crlf_q <= held_crlf_d;
    held_nonl_q <= held_nonl_d;
  end

endmodule

>>> design/mhlp_queue.sv
// Result queue that takes up to two words a cycle and delivers one unless the output is stalled.
module mhlp_queue import mhlp_pkg::*; #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  push_t            push_i,
  input  logic [WIDTH-1:0] data_a_i,
  input  logic [WIDTH-1:0] data_b_i,
  input  logic             out_stall_i,
  output logic             out_valid_o,
  output logic [WIDTH-1:0] out_data_o,
  output q_status_t        status_o
);

  logic [WIDTH-1:0]   mem_q [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_q, rd_q;
  logic [Q_CNT_W-1:0] cnt_q;
  logic [Q_CNT_W-1:0] n_push;
  logic [WIDTH-1:0]   first_data;
  logic               pop;
  logic [Q_PTR_W-1:0] wr_next_slot;

  assign n_push = Q_CNT_W'(push_i.a_valid) + Q_CNT_W'(push_i.b_valid);
  assign first_data = push_i.a_valid ? data_a_i : data_b_i;
  assign wr_next_slot = wr_q + Q_PTR_W'(1);
  assign pop = (cnt_q != '0) && !out_stall_i;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];

  // The parser may hand over two words per item, so the input side stops
  // while fewer than four slots are free.
  assign status_o.level     = cnt_q;
  assign status_o.low_space = (cnt_q > Q_CNT_W'(Q_DEPTH - 4));

  always_ff @(posedge clk_i) begin
    if (push_i.a_valid || push_i.b_valid) begin
      mem_q[wr_q] <= first_data;
    end
    if (push_i.a_valid && push_i.b_valid) begin
      mem_q[wr_next_slot] <= data_b_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + n_push[Q_PTR_W-1:0];
      if (pop) begin
        rd_q <= rd_q + Q_PTR_W'(1);
      end
      cnt_q <= cnt_q + n_push - Q_CNT_W'(pop);
    end
  end

endmodule

>>> design/mail_header_line_parser.sv
// Mail header line parser: one byte per cycle in unless stalled, one record per line out.
// A taken byte is captured in the input register and its records then go into the result
// queue, which offers them in order; a line's record comes with the next line's first byte.
// Throughput is one byte per cycle unless stalled; an item yielding two records delivers
// them one at a time, and the input stalls while the queue has fewer than four free slots.
// Reset clears all line state, totals and the queue; the space-skip register resets to 1.
`include "mail_header_line_parser_defines.svh"

module mail_header_line_parser import mhlp_pkg::*; #(
  parameter int LEN_BITS   = LEN_BITS_DEF,
  parameter int TOTAL_BITS = TOTAL_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  end_of_input_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [1:0]            line_kind_o,
  output logic [LEN_BITS-1:0]   name_length_o,
  output logic [LEN_BITS-1:0]   middle_length_o,
  output logic [LEN_BITS-1:0]   value_length_o,
  output logic                  ends_crlf_o,
  output logic                  lacks_newline_o,
  output logic                  next_continues_o,
  output logic                  saw_nul_o,
  output logic [TOTAL_BITS-1:0] lines_total_o,
  output logic [TOTAL_BITS-1:0] physical_total_o,
  output logic [TOTAL_BITS-1:0] virtual_total_o,
  output logic                  last_of_run_o
);

  typedef struct packed {
    kind_e                 kind;
    logic [LEN_BITS-1:0]   name;
    logic [LEN_BITS-1:0]   middle;
    logic [LEN_BITS-1:0]   value;
    logic                  crlf;
    logic                  nonl;
    logic                  cont;
    logic                  nul;
    logic [TOTAL_BITS-1:0] lines;
    logic [TOTAL_BITS-1:0] phys;
    logic [TOTAL_BITS-1:0] virt;
    logic                  last;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  push_t            push;
  q_status_t        q_stat;
  logic [REC_W-1:0] rec_a, rec_b, rec_out;
  rec_t             rec;

  assign in_stall_o = q_stat.low_space;

  mhlp_core #(
    .LEN_BITS   (LEN_BITS),
    .TOTAL_BITS (TOTAL_BITS),
    .REC_W      (REC_W)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .stall_i        (q_stat.low_space),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .push_o         (push),
    .rec_a_o        (rec_a),
    .rec_b_o        (rec_b)
  );

  mhlp_queue #(
    .WIDTH (REC_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_a_i    (rec_a),
    .data_b_i    (rec_b),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (rec_out),
    .status_o    (q_stat)
  );

  assign rec = rec_out;

  assign line_kind_o      = rec.kind;
  assign name_length_o    = rec.name;
  assign middle_length_o  = rec.middle;
  assign value_length_o   = rec.value;
  assign ends_crlf_o      = rec.crlf;
  assign lacks_newline_o  = rec.nonl;
  assign next_continues_o = rec.cont;
  assign saw_nul_o        = rec.nul;
  assign lines_total_o    = rec.lines;
  assign physical_total_o = rec.phys;
  assign virtual_total_o  = rec.virt;
  assign last_of_run_o    = rec.last;

  // The queue must have room for both words whenever the parser pushes two.
  `MHLP_ASSERT_IMP(a_push_room, push.a_valid && push.b_valid, q_stat.level <= Q_CNT_W'(Q_DEPTH - 2))
  `MHLP_ASSERT(a_level_bound, q_stat.level <= Q_CNT_W'(Q_DEPTH))
  // An end of headers record is always the final record of its byte.
  `MHLP_ASSERT_IMP(a_end_is_last, out_valid_o && (line_kind_o == KIND_END), last_of_run_o)
  `MHLP_ASSERT_IMP(a_nonl_flags, out_valid_o && lacks_newline_o, !next_continues_o && !ends_crlf_o)

endmodule
